/* rtl/accel_tilt_angle_smoother_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tilt angle smoother
// Shared concurrent check forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLE_SMOOTHER_TOP_MACROS_SVH
`define ACCEL_TILT_ANGLE_SMOOTHER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ATAS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("atas check failed");

// antecedent implies consequent in the next cycle
`define ATAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("atas check failed");

`endif

/* rtl/atas_pkg.sv */
// ----------------------------------------------------------------------------
// atas_pkg
// Types, widths and constants shared by the tilt angle smoother.
// ----------------------------------------------------------------------------
package atas_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int ACC_FRAC        = 16;
    localparam int ATAN_LEN        = 24;
    localparam int IT_W            = $clog2(CORDIC_STEPS);

    localparam int CAL_W   = 32;  // calibrated axis, signed
    localparam int MAG_W   = 31;  // magnitude of a calibrated axis
    localparam int SQ_W    = 62;  // sum of two squares
    localparam int ROOT_W  = 31;
    localparam int REM_W   = 34;
    localparam int SQ_CNT  = SQ_W / 2;
    localparam int SQC_W   = $clog2(SQ_CNT);
    localparam int VEC_W   = 35;  // CORDIC x / y
    localparam int Z_W     = 28;  // CORDIC angle accumulator, Q16 degrees
    localparam int SH      = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ANG_W   = Z_W - SH;
    localparam int A_W     = 20;  // clamped angle work width
    localparam int PROD_W  = A_W + 17;

    localparam int ONE_DEG = 1 << ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] HALF_TURN_Z = Z_W'(180 * (1 << ACC_FRAC));

    localparam logic [22:0] ATAN_TAB [ATAN_LEN] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
        23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7,
        23'd4, 23'd2, 23'd1, 23'd0
    };

    typedef enum logic [2:0] {
        L_IDLE, L_SQP, L_SQQ, L_ROOT, L_INIT, L_ROT, L_DONE
    } lane_state_t;

    typedef enum logic [2:0] {
        T_IDLE, T_CAL, T_LANES, T_PROD, T_SUM, T_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        R_OFF_X, R_OFF_Y, R_OFF_Z, R_GAIN_X, R_GAIN_Y, R_GAIN_Z, R_WEIGHT, R_NONE
    } reg_idx_t;

    typedef struct packed {
        logic prod;  // clamp and multiply
        logic sum;   // commit smoothed angles
    } merge_ctl_t;

endpackage

/* rtl/atas_calib.sv */
// ----------------------------------------------------------------------------
// atas_calib
// Per-axis calibration: (16*raw - offset) * inverse gain, registered.
// ----------------------------------------------------------------------------
module atas_calib (
    input  logic                              aclk,
    input  logic                              load,
    input  logic signed [9:0]                 raw_x,
    input  logic signed [9:0]                 raw_y,
    input  logic signed [9:0]                 raw_z,
    input  logic signed [13:0]                off_x,
    input  logic signed [13:0]                off_y,
    input  logic signed [13:0]                off_z,
    input  logic [15:0]                       gain_x,
    input  logic [15:0]                       gain_y,
    input  logic [15:0]                       gain_z,
    output logic signed [atas_pkg::CAL_W-1:0] ax,
    output logic signed [atas_pkg::CAL_W-1:0] ay,
    output logic signed [atas_pkg::CAL_W-1:0] az
);
    logic signed [14:0] dx, dy, dz;
    logic signed [atas_pkg::CAL_W-1:0] ax_reg, ay_reg, az_reg;

    assign dx = $signed({raw_x, 4'b0}) - 15'(off_x);
    assign dy = $signed({raw_y, 4'b0}) - 15'(off_y);
    assign dz = $signed({raw_z, 4'b0}) - 15'(off_z);

    always_ff @(posedge aclk) begin
        if (load) begin
            ax_reg <= atas_pkg::CAL_W'(dx * $signed({1'b0, gain_x}));
            ay_reg <= atas_pkg::CAL_W'(dy * $signed({1'b0, gain_y}));
            az_reg <= atas_pkg::CAL_W'(dz * $signed({1'b0, gain_z}));
        end
    end

    assign ax = ax_reg;
    assign ay = ay_reg;
    assign az = az_reg;
endmodule

/* rtl/atas_lane.sv */
// ----------------------------------------------------------------------------
// atas_lane
// One angle lane: sqrt(p^2 + q^2) digit by digit, then vectoring CORDIC atan2.
// swap low: atan2(o, mag); swap high: atan2(mag, o).
// ----------------------------------------------------------------------------
module atas_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic                              swap,
    input  logic signed [atas_pkg::CAL_W-1:0] p,
    input  logic signed [atas_pkg::CAL_W-1:0] q,
    input  logic signed [atas_pkg::CAL_W-1:0] o,
    output logic                              done,
    output logic signed [atas_pkg::ANG_W-1:0] angle
);
    atas_pkg::lane_state_t state_reg, state_next;
    logic [atas_pkg::SQC_W-1:0]        sc_reg;
    logic [atas_pkg::IT_W-1:0]         it_reg;
    logic [atas_pkg::SQ_W-1:0]         sum_reg;
    logic [atas_pkg::REM_W-1:0]        rem_reg;
    logic [atas_pkg::ROOT_W-1:0]       root_reg;
    logic signed [atas_pkg::VEC_W-1:0] x_reg, y_reg;
    logic signed [atas_pkg::Z_W-1:0]   z_reg;
    logic                              zero_reg;

    logic signed [atas_pkg::CAL_W-1:0] sel;
    logic [atas_pkg::MAG_W-1:0]        mag;
    logic [atas_pkg::SQ_W-1:0]         sq;
    logic [atas_pkg::REM_W-1:0]        rem_sh, trial;
    logic signed [atas_pkg::VEC_W-1:0] ix, iy, dx, dy;
    logic signed [atas_pkg::Z_W-1:0]   tab, zr;

    assign sel   = (state_reg == atas_pkg::L_SQP) ? p : q;
    assign mag   = atas_pkg::MAG_W'(sel < 0 ? -sel : sel);
    assign sq    = atas_pkg::SQ_W'(mag * mag);
    assign rem_sh = {rem_reg[atas_pkg::REM_W-3:0], sum_reg[atas_pkg::SQ_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ix = swap ? atas_pkg::VEC_W'(o) : atas_pkg::VEC_W'({1'b0, root_reg});
    assign iy = swap ? atas_pkg::VEC_W'({1'b0, root_reg}) : atas_pkg::VEC_W'(o);
    assign dx = y_reg >>> it_reg;
    assign dy = x_reg >>> it_reg;
    assign tab = atas_pkg::Z_W'(atas_pkg::ATAN_TAB[it_reg]);
    assign zr  = z_reg + atas_pkg::Z_W'(1 << (atas_pkg::SH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= atas_pkg::L_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            atas_pkg::L_IDLE, atas_pkg::L_DONE: begin
                if (start) state_next = atas_pkg::L_SQP;
            end
            atas_pkg::L_SQP:  state_next = atas_pkg::L_SQQ;
            atas_pkg::L_SQQ:  state_next = atas_pkg::L_ROOT;
            atas_pkg::L_ROOT: begin
                if (sc_reg == atas_pkg::SQC_W'(atas_pkg::SQ_CNT - 1))
                    state_next = atas_pkg::L_INIT;
            end
            atas_pkg::L_INIT: state_next = atas_pkg::L_ROT;
            atas_pkg::L_ROT: begin
                if (it_reg == atas_pkg::IT_W'(atas_pkg::CORDIC_STEPS - 1))
                    state_next = atas_pkg::L_DONE;
            end
            default: state_next = atas_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            atas_pkg::L_SQP: begin
                sum_reg  <= sq;
                sc_reg   <= '0;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            atas_pkg::L_SQQ: sum_reg <= sum_reg + sq;
            atas_pkg::L_ROOT: begin
                sum_reg <= {sum_reg[atas_pkg::SQ_W-3:0], 2'b00};
                sc_reg  <= sc_reg + 1'b1;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[atas_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[atas_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            atas_pkg::L_INIT: begin
                it_reg   <= '0;
                zero_reg <= (ix == 0) && (iy == 0);
                if (ix < 0) begin
                    x_reg <= -ix;
                    y_reg <= -iy;
                    z_reg <= (iy >= 0) ? atas_pkg::HALF_TURN_Z : -atas_pkg::HALF_TURN_Z;
                end else begin
                    x_reg <= ix;
                    y_reg <= iy;
                    z_reg <= '0;
                end
            end
            atas_pkg::L_ROT: begin
                it_reg <= it_reg + 1'b1;
                if (y_reg > 0) begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + tab;
                end else begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - tab;
                end
            end
            default: ;
        endcase
    end

    assign done  = (state_reg == atas_pkg::L_DONE);
    assign angle = zero_reg ? '0 : atas_pkg::ANG_W'(zr >>> atas_pkg::SH);
endmodule

/* rtl/atas_merge.sv */
// ----------------------------------------------------------------------------
// atas_merge
// Clamps the lane angles, mirrors pitch, and runs the three smoothers.
// ----------------------------------------------------------------------------
module atas_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  atas_pkg::merge_ctl_t              ctl,
    input  logic signed [atas_pkg::ANG_W-1:0] roll_raw,
    input  logic signed [atas_pkg::ANG_W-1:0] pitch_raw,
    input  logic signed [atas_pkg::ANG_W-1:0] tilt_raw,
    input  logic                              z_neg,
    input  logic [15:0]                       weight,
    output logic signed [14:0]                roll_mem,
    output logic [15:0]                       pitch_mem,
    output logic [14:0]                       tilt_mem
);
    localparam logic signed [atas_pkg::A_W-1:0] D90  = atas_pkg::A_W'(90 * atas_pkg::ONE_DEG);
    localparam logic signed [atas_pkg::A_W-1:0] D180 = atas_pkg::A_W'(180 * atas_pkg::ONE_DEG);
    localparam logic signed [atas_pkg::A_W-1:0] D360 = atas_pkg::A_W'(360 * atas_pkg::ONE_DEG);
    localparam logic signed [atas_pkg::PROD_W-1:0] RND = atas_pkg::PROD_W'(32768);

    logic signed [14:0] roll_reg;
    logic [15:0]        pitch_reg;
    logic [14:0]        tilt_reg;
    logic signed [atas_pkg::PROD_W-1:0] pr_reg, pp_reg, pt_reg;

    logic signed [atas_pkg::A_W-1:0] r_a, p_s, p_c, p_a, t_a, t_s;
    logic signed [atas_pkg::A_W-1:0] mr, mp, mt;
    logic signed [16:0]              w;

    assign w   = $signed({1'b0, weight});
    assign mr  = atas_pkg::A_W'(roll_reg);
    assign mp  = $signed(atas_pkg::A_W'(pitch_reg));
    assign mt  = $signed(atas_pkg::A_W'(tilt_reg));
    assign r_a = (atas_pkg::A_W'(roll_raw) < -D90) ? -D90 :
                 (atas_pkg::A_W'(roll_raw) > D90) ? D90 : atas_pkg::A_W'(roll_raw);
    assign p_s = D90 + atas_pkg::A_W'(pitch_raw);
    assign p_c = (p_s < 0) ? '0 : (p_s > D180) ? D180 : p_s;
    assign p_a = z_neg ? D360 - p_c : p_c;
    assign t_s = atas_pkg::A_W'(tilt_raw);
    assign t_a = (t_s < 0) ? '0 : (t_s > D180) ? D180 : t_s;

    always_ff @(posedge aclk) begin
        if (ctl.prod) begin
            pr_reg <= atas_pkg::PROD_W'((r_a - mr) * w);
            pp_reg <= atas_pkg::PROD_W'((p_a - mp) * w);
            pt_reg <= atas_pkg::PROD_W'((t_a - mt) * w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_reg  <= '0;
            pitch_reg <= '0;
            tilt_reg  <= '0;
        end else if (ctl.sum) begin
            roll_reg  <= 15'(mr + atas_pkg::A_W'((pr_reg + RND) >>> 16));
            pitch_reg <= 16'(mp + atas_pkg::A_W'((pp_reg + RND) >>> 16));
            tilt_reg  <= 15'(mt + atas_pkg::A_W'((pt_reg + RND) >>> 16));
        end
    end

    assign roll_mem  = roll_reg;
    assign pitch_mem = pitch_reg;
    assign tilt_mem  = tilt_reg;
endmodule

/* rtl/accel_tilt_angle_smoother_top.sv */
// ----------------------------------------------------------------------------
// accel_tilt_angle_smoother_top
// Per request: calibrate, square p and q, 31 root digits, CORDIC setup,
//   16 CORDIC steps, lane done, clamp and multiply, smoothing commit, output
//   load; the three lanes run side by side.
// Accepts one request at a time: the next is taken only after the previous result is loaded into the output register.
// Reset (aresetn low, synchronous): registers to defaults, smoothed angles to 0.
// ----------------------------------------------------------------------------
module accel_tilt_angle_smoother_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // raw_x[9:0], raw_y[19:10], raw_z[29:20], pad
    // result request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll[14:0], pitch[30:15], tilt_z[45:31], pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
`include "accel_tilt_angle_smoother_top_macros.svh"

    atas_pkg::top_state_t state_reg, state_next;

    // configuration registers
    logic signed [13:0] off_x_reg, off_y_reg, off_z_reg;
    logic [15:0]        gain_x_reg, gain_y_reg, gain_z_reg, weight_reg;
    atas_pkg::reg_idx_t ridx;
    logic               wr;

    logic               zneg_reg;
    logic               out_valid_reg;
    logic [47:0]        out_data_reg;

    logic signed [atas_pkg::CAL_W-1:0] ax, ay, az;
    logic [2:0]                        lane_done;
    logic signed [atas_pkg::ANG_W-1:0] roll_a, pitch_a, tilt_a;
    logic                              lane_go, accept;
    atas_pkg::merge_ctl_t              mctl;
    logic signed [14:0]                roll_mem;
    logic [15:0]                       pitch_mem;
    logic [14:0]                       tilt_mem;

    assign pready = 1'b1;
    assign ridx   = atas_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_x_reg  <= 14'sd41;
            off_y_reg  <= -14'sd205;
            off_z_reg  <= 14'sd102;
            gain_x_reg <= 16'd29521;
            gain_y_reg <= 16'd29789;
            gain_z_reg <= 16'd32605;
            weight_reg <= 16'd13107;
        end else if (wr) begin
            unique case (ridx)
                atas_pkg::R_OFF_X:  off_x_reg  <= pwdata[13:0];
                atas_pkg::R_OFF_Y:  off_y_reg  <= pwdata[13:0];
                atas_pkg::R_OFF_Z:  off_z_reg  <= pwdata[13:0];
                atas_pkg::R_GAIN_X: gain_x_reg <= pwdata[15:0];
                atas_pkg::R_GAIN_Y: gain_y_reg <= pwdata[15:0];
                atas_pkg::R_GAIN_Z: gain_z_reg <= pwdata[15:0];
                atas_pkg::R_WEIGHT: weight_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            atas_pkg::R_OFF_X:  prdata = {18'b0, off_x_reg};
            atas_pkg::R_OFF_Y:  prdata = {18'b0, off_y_reg};
            atas_pkg::R_OFF_Z:  prdata = {18'b0, off_z_reg};
            atas_pkg::R_GAIN_X: prdata = {16'b0, gain_x_reg};
            atas_pkg::R_GAIN_Y: prdata = {16'b0, gain_y_reg};
            atas_pkg::R_GAIN_Z: prdata = {16'b0, gain_z_reg};
            atas_pkg::R_WEIGHT: prdata = {16'b0, weight_reg};
            default:            prdata = '0;
        endcase
    end

    // one request in flight; the output register frees the input side
    assign s_tready = (state_reg == atas_pkg::T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign lane_go  = (state_reg == atas_pkg::T_CAL);
    assign mctl.prod = (state_reg == atas_pkg::T_PROD);
    assign mctl.sum  = (state_reg == atas_pkg::T_SUM);

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= atas_pkg::T_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            atas_pkg::T_IDLE:  if (accept) state_next = atas_pkg::T_CAL;
            atas_pkg::T_CAL:   state_next = atas_pkg::T_LANES;
            atas_pkg::T_LANES: if (&lane_done) state_next = atas_pkg::T_PROD;
            atas_pkg::T_PROD:  state_next = atas_pkg::T_SUM;
            atas_pkg::T_SUM:   state_next = atas_pkg::T_OUT;
            atas_pkg::T_OUT:   if (!out_valid_reg || m_tready) state_next = atas_pkg::T_IDLE;
            default:           state_next = atas_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) zneg_reg <= s_tdata[29];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == atas_pkg::T_OUT && (!out_valid_reg || m_tready)) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == atas_pkg::T_OUT && (!out_valid_reg || m_tready))
            out_data_reg <= {2'b00, tilt_mem, pitch_mem, roll_mem};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    atas_calib u_calib (
        .aclk   (aclk),
        .load   (accept),
        .raw_x  (s_tdata[9:0]),
        .raw_y  (s_tdata[19:10]),
        .raw_z  (s_tdata[29:20]),
        .off_x  (off_x_reg),
        .off_y  (off_y_reg),
        .off_z  (off_z_reg),
        .gain_x (gain_x_reg),
        .gain_y (gain_y_reg),
        .gain_z (gain_z_reg),
        .ax     (ax),
        .ay     (ay),
        .az     (az)
    );

    // roll: atan2(ay, |xz|)
    atas_lane u_lane_roll (
        .aclk (aclk), .aresetn (aresetn), .start (lane_go), .swap (1'b0),
        .p (ax), .q (az), .o (ay), .done (lane_done[0]), .angle (roll_a)
    );

    // pitch: atan2(ax, |yz|)
    atas_lane u_lane_pitch (
        .aclk (aclk), .aresetn (aresetn), .start (lane_go), .swap (1'b0),
        .p (ay), .q (az), .o (ax), .done (lane_done[1]), .angle (pitch_a)
    );

    // tilt: atan2(|xy|, az)
    atas_lane u_lane_tilt (
        .aclk (aclk), .aresetn (aresetn), .start (lane_go), .swap (1'b1),
        .p (ax), .q (ay), .o (az), .done (lane_done[2]), .angle (tilt_a)
    );

    atas_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mctl),
        .roll_raw  (roll_a),
        .pitch_raw (pitch_a),
        .tilt_raw  (tilt_a),
        .z_neg     (zneg_reg),
        .weight    (weight_reg),
        .roll_mem  (roll_mem),
        .pitch_mem (pitch_mem),
        .tilt_mem  (tilt_mem)
    );

    `ATAS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `ATAS_ASSERT_NEXT(a_sum_to_out, state_reg == atas_pkg::T_SUM, state_reg == atas_pkg::T_OUT)
    `ATAS_ASSERT_NEXT(a_hold_pending, state_reg == atas_pkg::T_OUT && m_tvalid && !m_tready, state_reg == atas_pkg::T_OUT)
    `ATAS_ASSERT_SAME(a_pitch_range, m_tvalid, m_tdata[30:15] <= 16'd46080)

endmodule
